// File: src/cbsa_pkg.sv
// cbsa_pkg: shared types and constants of the clipped blit unit
// payload words, command and register codes, controller states
// no dependencies
`timescale 1ns / 1ps

package cbsa_pkg;

  localparam int MaxFrameDimDefault = 256;
  localparam int CfgIndexW = 3;
  localparam int CfgDataW = 16;
  localparam logic [7:0] PixMax = 8'd255;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_BLIT = 2'd1,
    CMD_READ = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_SPRITE_WIDTH  = 3'd0,
    CFG_SPRITE_HEIGHT = 3'd1,
    CFG_FRAME_WIDTH   = 3'd2,
    CFG_FRAME_HEIGHT  = 3'd3,
    CFG_CENTRE_X      = 3'd4,
    CFG_CENTRE_Y      = 3'd5,
    CFG_BLEND_MODE    = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_ADDR,
    ST_READ,
    ST_WB
  } state_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [15:0] frame_addr;
    logic [7:0]  sprite_col;
    logic [7:0]  sprite_row;
    logic [7:0]  pixel_value;
  } in_word_t;

  typedef struct packed {
    logic [7:0] result_pixel;
    logic       pixel_written;
  } out_word_t;

  typedef struct packed {
    logic capture;
    logic calc_en;
    logic addr_en;
    logic rd_en;
    logic wb_en;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

// File: src/cbsa_ram.sv
// cbsa_ram: generic single port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module cbsa_ram #(
  parameter int Width = 8,
  parameter int Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/cbsa_ctrl.sv
// cbsa_ctrl: sequencer of the blit unit, one word through five steps
// depends on cbsa_pkg
`timescale 1ns / 1ps

module cbsa_ctrl import cbsa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd_o.calc_en = 1'b1;
        state_d = ST_ADDR;
      end
      ST_ADDR: begin
        cmd_o.addr_en = 1'b1;
        state_d = ST_READ;
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d = ST_WB;
      end
      ST_WB: begin
        if (!status_i.out_busy) begin
          cmd_o.wb_en = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: src/cbsa_datapath.sv
// cbsa_datapath: config registers, clipping, address arithmetic, blend, output register
// depends on cbsa_pkg and cbsa_ram
`timescale 1ns / 1ps

module cbsa_datapath import cbsa_pkg::*; #(
  parameter int MAX_FRAME_DIM = MaxFrameDimDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  in_word_t             in_word_i,
  input  dp_cmd_t              cmd_i,
  output dp_status_t           status_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_word_t            out_word_o
);

  localparam int StoreDepth = MAX_FRAME_DIM * MAX_FRAME_DIM;
  localparam int AW = $clog2(StoreDepth);
  localparam int DW = $clog2(MAX_FRAME_DIM + 1);
  localparam int XW = $clog2(MAX_FRAME_DIM);

  logic [8:0]         sw_q, sh_q, fwr_q, fhr_q;
  logic signed [10:0] cx_q, cy_q;
  logic               blend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q    <= 9'd16;
      sh_q    <= 9'd16;
      fwr_q   <= 9'd256;
      fhr_q   <= 9'd256;
      cx_q    <= '0;
      cy_q    <= '0;
      blend_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SPRITE_WIDTH:  sw_q    <= cfg_data_i[8:0];
        CFG_SPRITE_HEIGHT: sh_q    <= cfg_data_i[8:0];
        CFG_FRAME_WIDTH:   fwr_q   <= cfg_data_i[8:0];
        CFG_FRAME_HEIGHT:  fhr_q   <= cfg_data_i[8:0];
        CFG_CENTRE_X:      cx_q    <= $signed(cfg_data_i[10:0]);
        CFG_CENTRE_Y:      cy_q    <= $signed(cfg_data_i[10:0]);
        CFG_BLEND_MODE:    blend_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // frame size saturated to the store geometry
  logic [DW-1:0] fw, fh;
  always_comb begin
    fw = (int'(fwr_q) > MAX_FRAME_DIM) ? DW'(MAX_FRAME_DIM) : DW'(fwr_q);
    fh = (int'(fhr_q) > MAX_FRAME_DIM) ? DW'(MAX_FRAME_DIM) : DW'(fhr_q);
  end

  in_word_t word_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      word_q <= in_word_i;
    end
  end

  // destination coordinates and clipping
  logic signed [11:0] dx, dy;
  logic               hit;
  always_comb begin
    dx = 12'(cx_q) - $signed({4'b0, sw_q[8:1]}) + $signed({4'b0, word_q.sprite_col});
    dy = 12'(cy_q) - $signed({4'b0, sh_q[8:1]}) + $signed({4'b0, word_q.sprite_row});
    hit = ({1'b0, word_q.sprite_col} < sw_q) && ({1'b0, word_q.sprite_row} < sh_q)
          && !dx[11] && !dy[11]
          && (int'(dx[10:0]) < int'(fw)) && (int'(dy[10:0]) < int'(fh));
  end

  logic [XW-1:0] dx_q, dy_q;
  logic          hit_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_en) begin
      dx_q  <= XW'(dx[10:0]);
      dy_q  <= XW'(dy[10:0]);
      hit_q <= hit;
    end
  end

  logic [AW-1:0] mem_addr_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.addr_en) begin
      if (word_q.cmd == CMD_BLIT) begin
        mem_addr_q <= AW'(int'(dy_q) * int'(fw) + int'(dx_q));
      end else begin
        mem_addr_q <= AW'(word_q.frame_addr);
      end
    end
  end

  logic [7:0] rdata;
  logic       ram_we;
  logic [7:0] res;
  logic [8:0] sum;
  logic       addr_ok;

  always_comb begin
    addr_ok = int'(word_q.frame_addr) < StoreDepth;
    sum = {1'b0, rdata} + {1'b0, word_q.pixel_value};
    res = '0;
    ram_we = 1'b0;
    unique case (word_q.cmd)
      CMD_LOAD: begin
        res = word_q.pixel_value;
        ram_we = addr_ok;
      end
      CMD_READ: begin
        res = addr_ok ? rdata : '0;
      end
      CMD_BLIT: begin
        if (hit_q) begin
          ram_we = 1'b1;
          if (blend_q) begin
            res = sum[8] ? PixMax : sum[7:0];
          end else begin
            res = word_q.pixel_value;
          end
        end
      end
      CMD_NONE: ;
      default: ;
    endcase
  end

  cbsa_ram #(
    .Width(8),
    .Depth(StoreDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wb_en && ram_we),
    .re_i   (cmd_i.rd_en),
    .addr_i (mem_addr_q),
    .wdata_i(res),
    .rdata_o(rdata)
  );

  logic      out_valid_q;
  out_word_t out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.wb_en) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wb_en) begin
      out_word_q.result_pixel  <= res;
      out_word_q.pixel_written <= ram_we;
    end
  end

  assign status_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o = out_word_q;

endmodule

// File: src/clipped_blit_saturating_add_unit.sv
// clipped_blit_saturating_add_unit: top level of the clipped sprite blit unit
// depends on cbsa_pkg, cbsa_ctrl, cbsa_datapath
`timescale 1ns / 1ps

// Each input word holds the unit through its steps: accept, clip, address
// multiply, frame store read, write back. It passes the word register, the
// clip and address registers and the frame store read register before its
// result reaches the output register, and the next word is taken only after
// write back. The sequence is set by the sequencer stepping one word through
// the single port frame store with its registered read; a stalled output holds
// the write back step. A new word is taken while the last result still waits
// to be taken. The frame store is not cleared after reset; entries are
// undefined until loaded. Configuration writes are always ready.
module clipped_blit_saturating_add_unit import cbsa_pkg::*; #(
  parameter int MAX_FRAME_DIM = MaxFrameDimDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_word_t             in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_word_t            out_word_o
);

  dp_cmd_t    ctrl_cmd;
  dp_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  cbsa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (dp_status),
    .cmd_o     (ctrl_cmd)
  );

  cbsa_datapath #(
    .MAX_FRAME_DIM(MAX_FRAME_DIM)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_word_i  (in_word_i),
    .cmd_i      (ctrl_cmd),
    .status_o   (dp_status),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted word did not make the unit busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.wb_en |-> !(out_valid_o && out_stall_i))
    else $error("write back over a pending result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.wb_en |=> out_valid_o)
    else $error("write back did not present a result");

endmodule
